### hw/rtl/mclw_pkg.sv
// Package for the motor command link watchdog.
// Holds register indexes, reset values and command bit masks; depends on nothing.
`default_nettype none

package mclw_pkg;

  // Configuration register indexes.
  localparam int unsigned CfgAddrW = 2;
  typedef logic [CfgAddrW-1:0] cfg_addr_t;

  localparam cfg_addr_t REG_WATCHDOG_WINDOW  = 2'd0;
  localparam cfg_addr_t REG_BLINK_OFF_FIRST  = 2'd1;
  localparam cfg_addr_t REG_BLINK_ON_SECOND  = 2'd2;
  localparam cfg_addr_t REG_BLINK_OFF_SECOND = 2'd3;

  // Field widths.
  localparam int unsigned ByteW  = 8;
  localparam int unsigned DutyW  = 16;
  localparam int unsigned TickW  = 16;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 40;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [DutyW-1:0] duty_t;
  typedef logic [TickW-1:0] tick_t;

  // Reset values of the configuration registers.
  localparam tick_t WINDOW_RST        = 16'd1000;
  localparam tick_t BLINK_OFF_1_RST   = 16'd50;
  localparam tick_t BLINK_ON_2_RST    = 16'd200;
  localparam tick_t BLINK_OFF_2_RST   = 16'd250;

  // Command byte masks.
  localparam byte_t CMD_ARMED_MASK  = 8'h80;
  localparam byte_t CMD_DOUBLE_MASK = 8'hA0;
  localparam byte_t CMD_LINK_MASK   = 8'h01;

  // Tick on which the arm LED always lights.
  localparam tick_t TICK_LED_ON = 16'd1;

endpackage

`default_nettype wire

### hw/rtl/motor_command_link_watchdog.sv
// Top level of the motor command link watchdog: frame check, duty registers,
// tick counter, watchdog window and arm LED blink pattern. Uses mclw_pkg.
`default_nettype none

// Channel   Direction  Handshake               Payload
// in_       slave      in_tvalid / in_tready   tdata: six frame bytes, tuser: has_frame
// out_      master     out_tvalid / out_tready tdata: duties and LED levels
// cfg_      write      cfg_we                  cfg_addr, cfg_wdata
//
// Every beat is handled combinationally: the frame checksum, the duty update, the
// tick counter step and the LED decision are all computed from the accepted
// beat and the current state, and land in the state and output registers at
// the same edge. A new beat is accepted every cycle while the output register
// is empty or being drained, so the block sustains one beat per clock.
// Reset is synchronous and active low; it restores the register defaults, the
// state and an empty output register. A stalled output holds its beat and
// stops input acceptance only while it is full and not taken.

module motor_command_link_watchdog (
  input  wire                           clk,
  input  wire                           rst_n,
  // Input beat.
  input  wire                           in_tvalid,
  output logic                          in_tready,
  // Bits from low: command[7:0], left_high[15:8], left_low[23:16],
  // right_high[31:24], right_low[39:32], frame_sum[47:40].
  input  wire  [mclw_pkg::InDataW-1:0]  in_tdata,
  // Bit 0: has_frame.
  input  wire                           in_tuser,
  // Result beat.
  output logic                          out_tvalid,
  input  wire                           out_tready,
  // Bits from low: duty_left_out[15:0], duty_right_out[31:16], arm_led[32],
  // link_led[33], zero fill [39:34].
  output logic [mclw_pkg::OutDataW-1:0] out_tdata,
  // Configuration write port.
  input  wire                           cfg_we,
  input  wire  [mclw_pkg::CfgAddrW-1:0] cfg_addr,
  input  wire  [mclw_pkg::TickW-1:0]    cfg_wdata
);

  import mclw_pkg::*;

  // Configuration registers.
  tick_t window_r, blink_off1_r, blink_on2_r, blink_off2_r;

  // Block state.
  duty_t duty_left_r,  duty_left_nxt;
  duty_t duty_right_r, duty_right_nxt;
  tick_t tick_r,       tick_nxt;
  byte_t last_cmd_r,   last_cmd_nxt;
  logic  fresh_r,      fresh_nxt;
  logic  arm_led_r,    arm_led_nxt;
  logic  link_led_r,   link_led_nxt;

  // Output register.
  logic                out_valid_r;
  logic [OutDataW-1:0] out_data_r, out_data_nxt;

  // Unpacked input fields.
  byte_t cmd, left_hi, left_lo, right_hi, right_lo, frame_sum, calc_sum;
  logic  accept, frame_ok, armed_ok;
  tick_t tick_inc;

  assign cmd       = in_tdata[7:0];
  assign left_hi   = in_tdata[15:8];
  assign left_lo   = in_tdata[23:16];
  assign right_hi  = in_tdata[31:24];
  assign right_lo  = in_tdata[39:32];
  assign frame_sum = in_tdata[47:40];

  // The output register frees up in the same cycle it is drained.
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  // The checksum is the byte sum modulo 256 of the first five bytes.
  assign calc_sum = cmd + left_hi + left_lo + right_hi + right_lo;
  assign frame_ok = in_tuser && (calc_sum == frame_sum);
  assign armed_ok = frame_ok && ((cmd & CMD_ARMED_MASK) != '0);
  assign tick_inc = tick_r + 1'b1;

  always_comb begin
    duty_left_nxt  = duty_left_r;
    duty_right_nxt = duty_right_r;
    fresh_nxt      = fresh_r;
    link_led_nxt   = link_led_r;
    arm_led_nxt    = arm_led_r;
    tick_nxt       = tick_inc;
    // The command byte is kept even when the checksum fails.
    last_cmd_nxt   = in_tuser ? cmd : last_cmd_r;

    if (frame_ok) begin
      if (armed_ok) begin
        duty_left_nxt  = {left_hi, left_lo};
        duty_right_nxt = {right_hi, right_lo};
        fresh_nxt      = 1'b1;
      end else begin
        duty_left_nxt  = '0;
        duty_right_nxt = '0;
      end
      link_led_nxt = (cmd & CMD_LINK_MASK) != '0;
    end

    // Window close: without an armed frame in this window the motors stop.
    if (tick_inc >= window_r) begin
      tick_nxt = '0;
      if (!fresh_nxt) begin
        duty_left_nxt  = '0;
        duty_right_nxt = '0;
      end
      fresh_nxt = 1'b0;
    end

    // Blink pattern; the first matching tick wins.
    if (tick_nxt == TICK_LED_ON) begin
      arm_led_nxt = 1'b1;
    end else if (tick_nxt == blink_off1_r &&
                 (last_cmd_nxt & CMD_ARMED_MASK) == CMD_ARMED_MASK) begin
      arm_led_nxt = 1'b0;
    end else if (tick_nxt == blink_on2_r &&
                 (last_cmd_nxt & CMD_DOUBLE_MASK) == CMD_DOUBLE_MASK) begin
      arm_led_nxt = 1'b1;
    end else if (tick_nxt == blink_off2_r &&
                 (last_cmd_nxt & CMD_DOUBLE_MASK) == CMD_DOUBLE_MASK) begin
      arm_led_nxt = 1'b0;
    end

    out_data_nxt = {6'd0, link_led_nxt, arm_led_nxt, duty_right_nxt, duty_left_nxt};
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r     <= WINDOW_RST;
      blink_off1_r <= BLINK_OFF_1_RST;
      blink_on2_r  <= BLINK_ON_2_RST;
      blink_off2_r <= BLINK_OFF_2_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_WATCHDOG_WINDOW:  window_r     <= cfg_wdata;
        REG_BLINK_OFF_FIRST:  blink_off1_r <= cfg_wdata;
        REG_BLINK_ON_SECOND:  blink_on2_r  <= cfg_wdata;
        REG_BLINK_OFF_SECOND: blink_off2_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // State registers advance once per accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_left_r  <= '0;
      duty_right_r <= '0;
      tick_r       <= '0;
      last_cmd_r   <= '0;
      fresh_r      <= 1'b0;
      arm_led_r    <= 1'b0;
      link_led_r   <= 1'b1;
    end else if (accept) begin
      duty_left_r  <= duty_left_nxt;
      duty_right_r <= duty_right_nxt;
      tick_r       <= tick_nxt;
      last_cmd_r   <= last_cmd_nxt;
      fresh_r      <= fresh_nxt;
      arm_led_r    <= arm_led_nxt;
      link_led_r   <= link_led_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef ASSERT_OFF
  // An empty output register never blocks the input.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled while output register empty");

  // Every accepted beat yields a result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted beat produced no result");

  // A pending result always mirrors the duty and LED state.
  a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r[15:0] == duty_left_r) &&
                    (out_data_r[31:16] == duty_right_r) &&
                    (out_data_r[32] == arm_led_r) && (out_data_r[33] == link_led_r))
    else $error("result register out of step with state");

  // A valid armed frame is remembered unless the window closed on that beat.
  a_fresh_set: assert property (@(posedge clk) disable iff (!rst_n)
    accept && armed_ok |=> fresh_r || (tick_r == '0))
    else $error("armed frame not recorded for watchdog");
`endif

endmodule

`default_nettype wire
